// File: sv/rkcf_pkg.sv
// ----------------------------------------------------------------------------
// rkcf_pkg
// Shared types and constants of the RGB 3x3 correlation filter.
// ----------------------------------------------------------------------------
package rkcf_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int COL_W      = 10;
  localparam int DIM_W      = 11;
  localparam int PIX_W      = 24;
  localparam int COEF_W     = 16;
  localparam int KROW_W     = 48;
  localparam int LINE_AW    = $clog2(MAX_WIDTH);

  // Register indexes (byte address is 8 * index).
  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_KTOP   = 3'd2;
  localparam logic [2:0] REG_KMID   = 3'd3;
  localparam logic [2:0] REG_KBOT   = 3'd4;
  localparam logic [2:0] REG_INV    = 3'd5;
  localparam logic [2:0] REG_BIAS   = 3'd6;

  typedef struct packed {
    logic [DIM_W-1:0]  image_width;
    logic [DIM_W-1:0]  image_height;
    logic [KROW_W-1:0] kernel_top;
    logic [KROW_W-1:0] kernel_middle;
    logic [KROW_W-1:0] kernel_bottom;
    logic [23:0]       inv_scale;
    logic [23:0]       bias;
  } cfg_t;

  typedef struct packed {
    logic clr;
    logic tap_en;
    logic scale_en;
  } dp_ctrl_t;

endpackage

// File: sv/rgb_kernel_correlation_filter.sv
// ----------------------------------------------------------------------------
// rgb_kernel_correlation_filter
// 3x3 correlation filter over a raster RGB stream with line-store memories.
// ----------------------------------------------------------------------------
// Each accepted pixel is read-modify-written into two line-store RAMs (a
// read state, then a write-back state), then every filtered pixel it completes
// is computed in turn: nine kernel taps through one multiplier per
// channel, one scaling multiply and one rounding step. An input transaction
// thus passes acceptance, read and write-back, then the compute of each result
// (up to four at the end of an image), plus any wait for a full output
// register. Results are held in an output register, so the next pixel is
// taken while the last result waits.
// Neighbors outside the image are replaced by the center row or column.
module rgb_kernel_correlation_filter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [9:0]  out_column,
  output logic [9:0]  out_row,
  output logic [31:0] out_red_out,
  output logic [31:0] out_green_out,
  output logic [31:0] out_blue_out,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_WB   = 3'd2;
  localparam logic [2:0] S_TAP  = 3'd3;
  localparam logic [2:0] S_SCL  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  rkcf_pkg::cfg_t     cfg;
  rkcf_pkg::dp_ctrl_t dp_ctrl;

  logic [2:0]  state_r, state_nxt;
  logic [9:0]  col_r, row_r, x_r, y_r;
  logic [23:0] pix_r;
  logic [23:0] win_r [3][3];
  logic [23:0] la_rd, lb_rd;
  logic [10:0] w_eff, h_eff;
  logic [3:0]  pend_r;
  logic        cxz_r, cyz_r, cur_last_r;
  logic [9:0]  cx_r, cy_r;
  logic [1:0]  tr_r, tc_r;
  logic        out_valid_r, out_last_r;
  logic [9:0]  out_col_r, out_row_r;
  logic [2:0][31:0] out_val_r;
  logic [2:0][31:0] dp_res;

  logic        accept, restart, wb, start, load_out, out_free;
  logic [3:0]  emit_mask, src_mask, pick;
  logic        left_e, right_e, top_e, bot_e;
  logic [1:0]  wr, wc;
  logic        skip;
  logic [23:0] tap_px;
  logic [47:0] krow;
  logic [15:0] coef;

  rkcf_regs u_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  assign w_eff = (cfg.image_width == 11'd0) ? 11'd1 :
                 (cfg.image_width > 11'(rkcf_pkg::MAX_WIDTH)) ?
                 11'(rkcf_pkg::MAX_WIDTH) : cfg.image_width;
  assign h_eff = (cfg.image_height == 11'd0) ? 11'd1 :
                 (cfg.image_height > 11'(rkcf_pkg::MAX_HEIGHT)) ?
                 11'(rkcf_pkg::MAX_HEIGHT) : cfg.image_height;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign restart  = ({1'b0, col_r} >= w_eff) || ({1'b0, row_r} >= h_eff);
  assign wb       = (state_r == S_WB);

  rkcf_ram #(.DEPTH(rkcf_pkg::MAX_WIDTH), .WIDTH(rkcf_pkg::PIX_W)) u_line_above (
    .clk  (clk),
    .we   (wb),
    .waddr(x_r),
    .wdata(pix_r),
    .re   (state_r == S_RD),
    .raddr(x_r),
    .rdata(la_rd)
  );

  rkcf_ram #(.DEPTH(rkcf_pkg::MAX_WIDTH), .WIDTH(rkcf_pkg::PIX_W)) u_line_two_above (
    .clk  (clk),
    .we   (wb),
    .waddr(x_r),
    .wdata(la_rd),
    .re   (state_r == S_RD),
    .raddr(x_r),
    .rdata(lb_rd)
  );

  // Results this pixel completes: row above first, then the last row.
  assign emit_mask[0] = (y_r != 10'd0) && (x_r != 10'd0);
  assign emit_mask[1] = (y_r != 10'd0) && ({1'b0, x_r} == w_eff - 11'd1);
  assign emit_mask[2] = ({1'b0, y_r} == h_eff - 11'd1) && (x_r != 10'd0);
  assign emit_mask[3] = ({1'b0, y_r} == h_eff - 11'd1) &&
                        ({1'b0, x_r} == w_eff - 11'd1);

  assign out_free = !out_valid_r || out_ready;
  assign load_out = (state_r == S_FIN) && out_free;
  assign src_mask = wb ? emit_mask : pend_r;
  assign start    = (wb && (emit_mask != 4'd0)) || (load_out && (pend_r != 4'd0));
  assign pick     = src_mask & (~src_mask + 4'd1);

  // Edge tests and window coordinates of the current tap.
  assign left_e  = (cx_r == 10'd0);
  assign right_e = ({1'b0, cx_r} == w_eff - 11'd1);
  assign top_e   = (cy_r == 10'd0);
  assign bot_e   = ({1'b0, cy_r} == h_eff - 11'd1);

  always_comb begin
    logic [1:0] cb, rb;
    cb = cxz_r ? 2'd2 : 2'd1;
    rb = cyz_r ? 2'd2 : 2'd1;
    case (tc_r)
      2'd0:    wc = left_e ? cb : cb - 2'd1;
      2'd2:    wc = right_e ? cb : cb + 2'd1;
      default: wc = cb;
    endcase
    case (tr_r)
      2'd0:    wr = top_e ? rb : rb - 2'd1;
      2'd2:    wr = bot_e ? rb : rb + 2'd1;
      default: wr = rb;
    endcase
    skip   = (wr == 2'd3) || (wc == 2'd3);
    tap_px = skip ? 24'd0 : win_r[wr][wc];
    case (tr_r)
      2'd0:    krow = cfg.kernel_top;
      2'd2:    krow = cfg.kernel_bottom;
      default: krow = cfg.kernel_middle;
    endcase
    case (tc_r)
      2'd0:    coef = krow[47:32];
      2'd2:    coef = krow[15:0];
      default: coef = krow[31:16];
    endcase
  end

  assign dp_ctrl = '{clr:      start,
                     tap_en:   (state_r == S_TAP) && !skip,
                     scale_en: (state_r == S_SCL)};

  rkcf_datapath u_dp (
    .clk      (clk),
    .ctrl     (dp_ctrl),
    .px       (tap_px),
    .coef     (coef),
    .inv_scale(cfg.inv_scale),
    .bias     (cfg.bias),
    .result   (dp_res)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept) state_nxt = S_RD;
      S_RD:   state_nxt = S_WB;
      S_WB:   state_nxt = (emit_mask != 4'd0) ? S_TAP : S_IDLE;
      S_TAP:  if (tr_r == 2'd2 && tc_r == 2'd2) state_nxt = S_SCL;
      S_SCL:  state_nxt = S_FIN;
      S_FIN:  if (out_free) state_nxt = (pend_r != 4'd0) ? S_TAP : S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_r[r][c] <= '0;
        end
      end
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        x_r   <= restart ? 10'd0 : col_r;
        y_r   <= restart ? 10'd0 : row_r;
        pix_r <= {in_red, in_green, in_blue};
      end
      if (wb) begin
        for (int r = 0; r < 3; r++) begin
          win_r[r][0] <= win_r[r][1];
          win_r[r][1] <= win_r[r][2];
        end
        win_r[0][2] <= lb_rd;
        win_r[1][2] <= la_rd;
        win_r[2][2] <= pix_r;
        if ({1'b0, x_r} >= w_eff - 11'd1) begin
          col_r <= '0;
          row_r <= ({1'b0, y_r} >= h_eff - 11'd1) ? 10'd0 : y_r + 10'd1;
        end else begin
          col_r <= x_r + 10'd1;
        end
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      pend_r     <= src_mask & ~pick;
      cur_last_r <= ((src_mask & ~pick) == 4'd0);
      cxz_r      <= pick[1] || pick[3];
      cyz_r      <= pick[2] || pick[3];
      cx_r       <= (pick[1] || pick[3]) ? x_r : x_r - 10'd1;
      cy_r       <= (pick[2] || pick[3]) ? y_r : y_r - 10'd1;
      tr_r       <= 2'd0;
      tc_r       <= 2'd0;
    end else if (state_r == S_TAP) begin
      if (tc_r == 2'd2) begin
        tc_r <= 2'd0;
        tr_r <= tr_r + 2'd1;
      end else begin
        tc_r <= tc_r + 2'd1;
      end
    end
    if (load_out) begin
      out_col_r  <= cx_r;
      out_row_r  <= cy_r;
      out_val_r  <= dp_res;
      out_last_r <= cur_last_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_column    = out_col_r;
  assign out_row       = out_row_r;
  assign out_red_out   = out_val_r[0];
  assign out_green_out = out_val_r[1];
  assign out_blue_out  = out_val_r[2];
  assign out_last      = out_last_r;

endmodule

// File: sv/rkcf_ram.sv
// ----------------------------------------------------------------------------
// rkcf_ram
// Simple dual-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module rkcf_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 24
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/rkcf_regs.sv
// ----------------------------------------------------------------------------
// rkcf_regs
// APB-style configuration registers of the correlation filter.
// ----------------------------------------------------------------------------
module rkcf_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [5:0]          paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready,
  output rkcf_pkg::cfg_t      cfg
);

  rkcf_pkg::cfg_t cfg_r;
  logic           wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width   <= 11'd640;
      cfg_r.image_height  <= 11'd480;
      cfg_r.kernel_top    <= '0;
      cfg_r.kernel_middle <= 48'd16777216;
      cfg_r.kernel_bottom <= '0;
      cfg_r.inv_scale     <= 24'd65536;
      cfg_r.bias          <= '0;
    end else if (wr_en) begin
      unique case (paddr[5:3])
        rkcf_pkg::REG_WIDTH:  cfg_r.image_width   <= pwdata[10:0];
        rkcf_pkg::REG_HEIGHT: cfg_r.image_height  <= pwdata[10:0];
        rkcf_pkg::REG_KTOP:   cfg_r.kernel_top    <= pwdata[47:0];
        rkcf_pkg::REG_KMID:   cfg_r.kernel_middle <= pwdata[47:0];
        rkcf_pkg::REG_KBOT:   cfg_r.kernel_bottom <= pwdata[47:0];
        rkcf_pkg::REG_INV:    cfg_r.inv_scale     <= pwdata[23:0];
        rkcf_pkg::REG_BIAS:   cfg_r.bias          <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[5:3])
      rkcf_pkg::REG_WIDTH:  prdata = {53'd0, cfg_r.image_width};
      rkcf_pkg::REG_HEIGHT: prdata = {53'd0, cfg_r.image_height};
      rkcf_pkg::REG_KTOP:   prdata = {16'd0, cfg_r.kernel_top};
      rkcf_pkg::REG_KMID:   prdata = {16'd0, cfg_r.kernel_middle};
      rkcf_pkg::REG_KBOT:   prdata = {16'd0, cfg_r.kernel_bottom};
      rkcf_pkg::REG_INV:    prdata = {40'd0, cfg_r.inv_scale};
      rkcf_pkg::REG_BIAS:   prdata = {40'd0, cfg_r.bias};
      default:              prdata = '0;
    endcase
  end

endmodule

// File: sv/rkcf_datapath.sv
// ----------------------------------------------------------------------------
// rkcf_datapath
// Per-channel multiply-accumulate, reciprocal scaling, rounding, bias and
// saturation for one filtered pixel.
// ----------------------------------------------------------------------------
module rkcf_datapath (
  input  logic                     clk,
  input  rkcf_pkg::dp_ctrl_t       ctrl,
  input  logic [23:0]              px,
  input  logic [15:0]              coef,
  input  logic [23:0]              inv_scale,
  input  logic [23:0]              bias,
  output logic [2:0][31:0]         result
);

  logic signed [28:0] acc_r [3];
  logic signed [53:0] p_r   [3];
  logic signed [24:0] prod  [3];
  logic signed [53:0] inv_s;

  assign inv_s = $signed({30'd0, inv_scale});

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod[c] = $signed({{9{coef[15]}}, coef}) *
                $signed({17'd0, px[16-8*c +: 8]});
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      if (ctrl.clr) begin
        acc_r[c] <= '0;
      end else if (ctrl.tap_en) begin
        acc_r[c] <= acc_r[c] + $signed({{4{prod[c][24]}}, prod[c]});
      end
      if (ctrl.scale_en) begin
        p_r[c] <= $signed({{25{acc_r[c][28]}}, acc_r[c]}) * inv_s;
      end
    end
  end

  // Round half up to Q.8, add the bias and clamp to 32 bits.
  always_comb begin
    logic signed [53:0] rsum;
    logic signed [38:0] v;
    for (int c = 0; c < 3; c++) begin
      rsum = p_r[c] + 54'sd32768;
      v = $signed({rsum[53], rsum[53:16]}) + $signed({{15{bias[23]}}, bias});
      if (v > 39'sd2147483647) begin
        result[c] = 32'h7FFF_FFFF;
      end else if (v < -39'sd2147483648) begin
        result[c] = 32'h8000_0000;
      end else begin
        result[c] = v[31:0];
      end
    end
  end

endmodule

// File: sv/rkcf_checker.sv
// ----------------------------------------------------------------------------
// rkcf_checker
// Port-level checks of the correlation filter, bound to the top level.
// ----------------------------------------------------------------------------
module rkcf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [9:0]  out_column,
  input logic [31:0] out_red_out,
  input logic        out_last,
  input logic        pready
);

  // A stalled result transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_column) &&
    $stable(out_red_out) && $stable(out_last))
    else $error("result changed while stalled");

  // One pixel is worked on at a time.
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // Reset empties the output register.
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready dropped");

endmodule

bind rgb_kernel_correlation_filter rkcf_checker u_rkcf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_column (out_column),
  .out_red_out(out_red_out),
  .out_last   (out_last),
  .pready     (pready)
);

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench of the RGB 3x3 correlation filter. Registers are
// programmed over the APB-style port while the filter is idle, pixel images
// of several geometries and kernels are streamed in, and every filtered pixel
// is compared against a behavioral model of the line stores and window.
// ----------------------------------------------------------------------------
module tb;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_red = '0, in_green = '0, in_blue = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [9:0]  out_column, out_row;
  logic [31:0] out_red_out, out_green_out, out_blue_out;
  logic        out_last;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  rgb_kernel_correlation_filter u_dut (.*);

  always #5 clk = ~clk;

  typedef struct {
    logic [9:0]  col;
    logic [9:0]  row;
    logic [31:0] r, g, b;
    logic        last;
  } pixel_res_t;

  pixel_res_t filtered_q[$];

  // Model copy of configuration and state.
  logic [10:0] m_width, m_height;
  logic [47:0] m_krow[3];
  logic [23:0] m_inv, m_bias;
  logic [23:0] m_above[rkcf_pkg::MAX_WIDTH];
  logic [23:0] m_two_above[rkcf_pkg::MAX_WIDTH];
  logic [23:0] m_win[9];
  int          m_col, m_row;

  int errors = 0;
  int results_seen = 0;
  int pixels_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  function automatic void model_reset();
    m_width = 11'd640;
    m_height = 11'd480;
    m_krow[0] = '0;
    m_krow[1] = 48'd16777216;
    m_krow[2] = '0;
    m_inv = 24'd65536;
    m_bias = '0;
    for (int i = 0; i < rkcf_pkg::MAX_WIDTH; i++) begin
      m_above[i] = '0;
      m_two_above[i] = '0;
    end
    for (int i = 0; i < 9; i++) m_win[i] = '0;
    m_col = 0;
    m_row = 0;
  endfunction

  function automatic void model_config(logic [2:0] idx, logic [63:0] val);
    case (idx)
      rkcf_pkg::REG_WIDTH:  m_width = val[10:0];
      rkcf_pkg::REG_HEIGHT: m_height = val[10:0];
      rkcf_pkg::REG_KTOP:   m_krow[0] = val[47:0];
      rkcf_pkg::REG_KMID:   m_krow[1] = val[47:0];
      rkcf_pkg::REG_KBOT:   m_krow[2] = val[47:0];
      rkcf_pkg::REG_INV:    m_inv = val[23:0];
      rkcf_pkg::REG_BIAS:   m_bias = val[23:0];
      default: ;
    endcase
  endfunction

  function automatic void filter_center(int cx, int cy, int x, int y, int w, int h);
    longint acc[3];
    longint v, p;
    int rr, cc, wr, wc;
    logic signed [15:0] cf;
    logic [23:0] px;
    pixel_res_t res;
    acc = '{0, 0, 0};
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        rr = cy + dr;
        cc = cx + dc;
        if (rr < 0 || rr >= h) rr = cy;
        if (cc < 0 || cc >= w) cc = cx;
        wr = rr - y + 2;
        wc = cc - x + 2;
        cf = 16'(m_krow[dr + 1] >> ((1 - dc) * 16));
        if (wr >= 0 && wr <= 2 && wc >= 0 && wc <= 2) begin
          px = m_win[wr * 3 + wc];
          for (int c = 0; c < 3; c++)
            acc[c] += longint'(cf) * longint'(px[16 - 8 * c +: 8]);
        end
      end
    end
    res.col = cx[9:0];
    res.row = cy[9:0];
    res.last = 1'b0;
    for (int c = 0; c < 3; c++) begin
      p = acc[c] * longint'({1'b0, m_inv}) + 64'sd32768;
      v = (p >>> 16) + longint'($signed(m_bias));
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      if (c == 0) res.r = v[31:0];
      else if (c == 1) res.g = v[31:0];
      else res.b = v[31:0];
    end
    filtered_q.push_back(res);
  endfunction

  function automatic void predict_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int w, h, x, y, n;
    logic [23:0] pix, la, lb;
    pixel_res_t tmp;
    w = (m_width == 0) ? 1 : (m_width > rkcf_pkg::MAX_WIDTH ? rkcf_pkg::MAX_WIDTH :
        int'(m_width));
    h = (m_height == 0) ? 1 : (m_height > rkcf_pkg::MAX_HEIGHT ? rkcf_pkg::MAX_HEIGHT :
        int'(m_height));
    if (m_col >= w || m_row >= h) begin
      m_col = 0;
      m_row = 0;
    end
    x = m_col;
    y = m_row;
    pix = {r, g, b};
    la = m_above[x];
    lb = m_two_above[x];
    m_two_above[x] = la;
    m_above[x] = pix;
    for (int i = 0; i < 3; i++) begin
      m_win[i * 3] = m_win[i * 3 + 1];
      m_win[i * 3 + 1] = m_win[i * 3 + 2];
    end
    m_win[2] = lb;
    m_win[5] = la;
    m_win[8] = pix;
    n = 0;
    if (y >= 1) begin
      if (x >= 1) begin filter_center(x - 1, y - 1, x, y, w, h); n++; end
      if (x == w - 1) begin filter_center(w - 1, y - 1, x, y, w, h); n++; end
    end
    if (y == h - 1) begin
      if (x >= 1) begin filter_center(x - 1, y, x, y, w, h); n++; end
      if (x == w - 1) begin filter_center(w - 1, y, x, y, w, h); n++; end
    end
    if (n > 0) begin
      tmp = filtered_q[$];
      tmp.last = 1'b1;
      filtered_q[$] = tmp;
    end
    if (x >= w - 1) begin
      m_col = 0;
      m_row = (y >= h - 1) ? 0 : y + 1;
    end else begin
      m_col = x + 1;
    end
  endfunction

  task automatic reg_write(logic [2:0] idx, logic [63:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    model_config(idx, val);
  endtask

  // The ready level is sampled mid-cycle, ahead of the edge that may take it.
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_red <= r;
    in_green <= g;
    in_blue <= b;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    predict_pixel(r, g, b);
    pixels_sent++;
  endtask

  // Waits for every expected result, then allows the worst-case compute time.
  task automatic drain();
    in_valid <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // Receiver: stalls at random and checks each transaction against the queue.
  always @(posedge clk) begin
    pixel_res_t e;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (filtered_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result col=%0d row=%0d", out_column, out_row);
      end else begin
        e = filtered_q.pop_front();
        if (e.col !== out_column || e.row !== out_row || e.r !== out_red_out ||
            e.g !== out_green_out || e.b !== out_blue_out || e.last !== out_last) begin
          errors++;
          if (errors <= 10)
            $display("mismatch exp (%0d,%0d) %h %h %h %b got (%0d,%0d) %h %h %h %b",
                     e.col, e.row, e.r, e.g, e.b, e.last, out_column, out_row,
                     out_red_out, out_green_out, out_blue_out, out_last);
        end
      end
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  typedef struct {
    logic [7:0] r, g, b;
  } pix_row_t;

  task automatic run_image(int w, int h, bit extremes);
    for (int i = 0; i < w * h; i++) begin
      case ($urandom_range(3))
        0: send_pixel(8'hFF, 8'hFF, 8'hFF);
        1: send_pixel(8'h00, 8'h00, 8'h00);
        default: send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
      endcase
      if (!extremes) ;
    end
  endtask

  task automatic random_kernel();
    reg_write(rkcf_pkg::REG_KTOP, {$urandom, $urandom});
    reg_write(rkcf_pkg::REG_KMID, {$urandom, $urandom});
    reg_write(rkcf_pkg::REG_KBOT, {$urandom, $urandom});
    reg_write(rkcf_pkg::REG_INV,
              $urandom_range(3) == 0 ? 64'd0 : 64'($urandom_range(24'hFFFFFF)));
    reg_write(rkcf_pkg::REG_BIAS, 64'($urandom & 24'hFFFFFF));
  endtask

  pix_row_t directed[12];

  initial begin
    model_reset();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: 3x4 image with identity kernel, then extreme kernels.
    directed = '{'{8'h00, 8'h00, 8'h00}, '{8'hFF, 8'hFF, 8'hFF}, '{8'h80, 8'h01, 8'h7F},
                 '{8'h01, 8'h02, 8'h04}, '{8'h10, 8'h20, 8'h40}, '{8'hFE, 8'h55, 8'hAA},
                 '{8'h33, 8'hCC, 8'h0F}, '{8'hF0, 8'h00, 8'hFF}, '{8'h00, 8'hFF, 8'h00},
                 '{8'h7F, 8'h80, 8'h81}, '{8'hFF, 8'h00, 8'hFF}, '{8'h12, 8'h34, 8'h56}};
    reg_write(rkcf_pkg::REG_WIDTH, 64'd3);
    reg_write(rkcf_pkg::REG_HEIGHT, 64'd4);
    foreach (directed[i]) send_pixel(directed[i].r, directed[i].g, directed[i].b);
    drain();
    // Extreme coefficients, full scale, lowest bias: saturation paths.
    reg_write(rkcf_pkg::REG_KTOP, 64'(48'h7FFF_7FFF_7FFF));
    reg_write(rkcf_pkg::REG_KMID, 64'(48'h7FFF_7FFF_7FFF));
    reg_write(rkcf_pkg::REG_KBOT, 64'(48'h8000_8000_8000));
    reg_write(rkcf_pkg::REG_INV, 64'hFF_FFFF);
    reg_write(rkcf_pkg::REG_BIAS, 64'h80_0000);
    reg_write(rkcf_pkg::REG_WIDTH, 64'd1);
    reg_write(rkcf_pkg::REG_HEIGHT, 64'd1);
    for (int i = 0; i < 3; i++) send_pixel(8'hFF, 8'h00, 8'hFF);
    drain();
    reg_write(rkcf_pkg::REG_KBOT, 64'(48'h7FFF_7FFF_7FFF));
    reg_write(rkcf_pkg::REG_BIAS, 64'h7F_FFFF);
    reg_write(rkcf_pkg::REG_WIDTH, 64'd0);
    reg_write(rkcf_pkg::REG_HEIGHT, 64'd0);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'h00, 8'hFF, 8'h00);
    drain();

    // Random images under the four idling phases. The tall single-column
    // image leaves its row count above the next height, so the wide image
    // that follows starts a fresh image.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      reg_write(rkcf_pkg::REG_WIDTH, ph == 7 ? 64'd1100 :
                (ph == 6 ? 64'd1 : 64'($urandom_range(1, 7))));
      reg_write(rkcf_pkg::REG_HEIGHT, ph == 6 ? 64'd1100 : 64'($urandom_range(1, 12)));
      random_kernel();
      if (ph >= 6) run_image(1, 20, 1'b0);
      else run_image(int'(m_width), int'(m_height), 1'b1);
      drain();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain();

    $display("Covered %0d pixels and %0d filtered results over several geometries,",
             pixels_sent, results_seen);
    $display("kernels, scales and biases with sender and receiver idling.");
    if (errors == 0 && filtered_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results outstanding", errors, filtered_q.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end
endmodule
